[sv/text_console_writer_assert.svh]
// ----------------------------------------------------------------------------
// text console writer assertion macros
// immediate-consequence and next-cycle property checks
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// consequent must hold in the same cycle
`define TCW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the following cycle
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// tcw_pkg
// shared widths, action and character codes, result record of the console
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  localparam int SCREEN_COLS_DEF = 80;
  localparam int SCREEN_ROWS_DEF = 25;

  localparam int ACTION_W = 3;
  localparam int CHAR_W   = 8;
  localparam int TCOL_W   = 7;
  localparam int TROW_W   = 5;
  localparam int COUNT_W  = 5;
  localparam int CROW_W   = 5;
  localparam int ATTR_W   = 8;
  localparam int OCOL_W   = 7;
  localparam int OROW_W   = 5;
  localparam int OFF_W    = 11;
  localparam int CELL_W   = CHAR_W + ATTR_W;

  localparam logic [ACTION_W-1:0] ACT_PUT    = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_MOVE   = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_SCROLL = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_READ   = 3'd4;

  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF        = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR        = 8'h0D;

  localparam int TAB_STEP = 8;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h1F;

  typedef struct packed {
    logic              done;
    logic [OCOL_W-1:0] cursor_col;
    logic [OROW_W-1:0] cursor_row;
    logic [OFF_W-1:0]  cursor_offset;
    logic [CHAR_W-1:0] cell_char;
    logic [ATTR_W-1:0] cell_attr;
  } res_t;

endpackage

`default_nettype wire

[sv/text_console_writer.sv]
// A request is taken when start is high and busy low; it steps through CALC, EXEC
// and OUT and its result strobes from the result register; the next request is
// taken in that strobe cycle. Scroll (count above zero) and a put that scrolls add
// a walk over the whole store, a clear a walk over the rows cleared: the walk moves
// one cell a cycle through the store ram. After reset busy stays high while the
// store is cleared; results are single-cycle strobes the receiver cannot stall.
// ----------------------------------------------------------------------------
// text_console_writer
// character-cell text console with screen store, cursor and attribute register
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_console_writer_assert.svh"

module text_console_writer #(
  parameter int SCREEN_COLS = tcw_pkg::SCREEN_COLS_DEF,
  parameter int SCREEN_ROWS = tcw_pkg::SCREEN_ROWS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [tcw_pkg::ACTION_W-1:0]  in_action,
  input  wire logic [tcw_pkg::CHAR_W-1:0]    in_char_code,
  input  wire logic [tcw_pkg::TCOL_W-1:0]    in_target_col,
  input  wire logic [tcw_pkg::TROW_W-1:0]    in_target_row,
  input  wire logic [tcw_pkg::COUNT_W-1:0]   in_scroll_count,
  input  wire logic [tcw_pkg::CROW_W-1:0]    in_clear_first_row,
  input  wire logic [tcw_pkg::CROW_W-1:0]    in_clear_end_row,
  output logic                               out_strobe,
  output logic      [tcw_pkg::OCOL_W-1:0]    out_cursor_col,
  output logic      [tcw_pkg::OROW_W-1:0]    out_cursor_row,
  output logic      [tcw_pkg::OFF_W-1:0]     out_cursor_offset,
  output logic      [tcw_pkg::CHAR_W-1:0]    out_cell_char,
  output logic      [tcw_pkg::ATTR_W-1:0]    out_cell_attr,
  input  wire logic                          cfg_we,
  input  wire logic [tcw_pkg::ATTR_W-1:0]    cfg_wdata
);

  localparam int CELLS = SCREEN_COLS * SCREEN_ROWS;
  localparam int AW    = $clog2(CELLS);

  logic [tcw_pkg::ATTR_W-1:0] attr_r;
  logic                       out_strobe_r;
  tcw_pkg::res_t              res;
  tcw_pkg::res_t              res_r;

  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [tcw_pkg::CELL_W-1:0] mem_wdata;
  logic [AW-1:0]              mem_raddr;
  logic [tcw_pkg::CELL_W-1:0] mem_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= tcw_pkg::ATTR_RESET;
    end else if (cfg_we) begin
      attr_r <= cfg_wdata;
    end
  end

  tcw_ctrl #(
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS)
  ) u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_action          (in_action),
    .in_char_code       (in_char_code),
    .in_target_col      (in_target_col),
    .in_target_row      (in_target_row),
    .in_scroll_count    (in_scroll_count),
    .in_clear_first_row (in_clear_first_row),
    .in_clear_end_row   (in_clear_end_row),
    .attr               (attr_r),
    .mem_we             (mem_we),
    .mem_waddr          (mem_waddr),
    .mem_wdata          (mem_wdata),
    .mem_raddr          (mem_raddr),
    .mem_rdata          (mem_rdata),
    .res                (res)
  );

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= res.done;
    end
  end

  always_ff @(posedge clk) begin
    if (res.done) begin
      res_r <= res;
    end
  end

  assign out_strobe        = out_strobe_r;
  assign out_cursor_col    = res_r.cursor_col;
  assign out_cursor_row    = res_r.cursor_row;
  assign out_cursor_offset = res_r.cursor_offset;
  assign out_cell_char     = res_r.cell_char;
  assign out_cell_attr     = res_r.cell_attr;

  `TCW_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "request taken but not busy")
  `TCW_ASSERT_NEXT(a_strobe_single, clk, rst_n, out_strobe_r, !out_strobe_r, "strobe held twice")
  `TCW_ASSERT_NOW(a_done_busy, clk, rst_n, res.done, busy, "result raised while idle")

endmodule

`default_nettype wire

[sv/tcw_ram.sv]
// ----------------------------------------------------------------------------
// tcw_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = tcw_pkg::CELL_W,
  parameter int DEPTH = tcw_pkg::SCREEN_COLS_DEF * tcw_pkg::SCREEN_ROWS_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[sv/tcw_ctrl.sv]
// ----------------------------------------------------------------------------
// tcw_ctrl
// action sequencer: cursor update, screen store walks and result assembly
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ctrl #(
  parameter int SCREEN_COLS = tcw_pkg::SCREEN_COLS_DEF,
  parameter int SCREEN_ROWS = tcw_pkg::SCREEN_ROWS_DEF,
  localparam int CELLS      = SCREEN_COLS * SCREEN_ROWS,
  localparam int AW         = $clog2(CELLS)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [tcw_pkg::ACTION_W-1:0]  in_action,
  input  wire logic [tcw_pkg::CHAR_W-1:0]    in_char_code,
  input  wire logic [tcw_pkg::TCOL_W-1:0]    in_target_col,
  input  wire logic [tcw_pkg::TROW_W-1:0]    in_target_row,
  input  wire logic [tcw_pkg::COUNT_W-1:0]   in_scroll_count,
  input  wire logic [tcw_pkg::CROW_W-1:0]    in_clear_first_row,
  input  wire logic [tcw_pkg::CROW_W-1:0]    in_clear_end_row,
  input  wire logic [tcw_pkg::ATTR_W-1:0]    attr,
  output logic                               mem_we,
  output logic      [AW-1:0]                 mem_waddr,
  output logic      [tcw_pkg::CELL_W-1:0]    mem_wdata,
  output logic      [AW-1:0]                 mem_raddr,
  input  wire logic [tcw_pkg::CELL_W-1:0]    mem_rdata,
  output tcw_pkg::res_t                      res
);

  localparam int CW  = $clog2(SCREEN_COLS);
  localparam int RW  = $clog2(SCREEN_ROWS);
  localparam int CW1 = CW + 1;
  localparam int RH  = RW + 1;
  localparam int AW1 = AW + 1;

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CALC  = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_WALK  = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state_r, state_nxt;

  logic [tcw_pkg::ACTION_W-1:0] act_r;
  logic [tcw_pkg::CHAR_W-1:0]   ch_r;
  logic [tcw_pkg::TCOL_W-1:0]   tcol_r;
  logic [tcw_pkg::TROW_W-1:0]   trow_r;
  logic [tcw_pkg::COUNT_W-1:0]  count_r;
  logic [tcw_pkg::CROW_W-1:0]   first_r;
  logic [tcw_pkg::CROW_W-1:0]   endrow_r;

  logic [CW-1:0]  cur_col_r, cur_col_nxt;
  logic [RW-1:0]  cur_row_r, cur_row_nxt;
  logic [AW1-1:0] prod_a_r, prod_a_nxt;
  logic [AW1-1:0] prod_b_r, prod_b_nxt;
  logic [RH-1:0]  k_r, k_nxt;
  logic [AW-1:0]  dst_r, dst_nxt;
  logic [AW1-1:0] src_r, src_nxt;
  logic [AW-1:0]  last_r, last_nxt;
  logic           clr_r, clr_nxt;
  logic           pend_r, pend_nxt;
  logic [AW-1:0]  pdst_r, pdst_nxt;
  logic           pblank_r, pblank_nxt;

  logic                       accept;
  logic [CW-1:0]              ccol;
  logic [RW-1:0]              crow;
  logic [RH-1:0]              kcl;
  logic [RH-1:0]              ecl;
  logic                       clr_none;
  logic [RH-1:0]              row_a;
  logic [AW-1:0]              put_addr;
  logic [AW-1:0]              rd_addr;
  logic [CW1-1:0]             col_w;
  logic [RH-1:0]              row_w;
  logic                       put_wr;
  logic                       put_scroll;
  logic [RW-1:0]              sc_row;
  logic                       src_in;
  logic [tcw_pkg::CELL_W-1:0] blank;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && (state_r == S_IDLE);
  assign blank  = {attr, {tcw_pkg::CHAR_W{1'b0}}};

  // clamped targets
  assign ccol = (32'(tcol_r) > SCREEN_COLS - 1) ? CW'(SCREEN_COLS - 1) : CW'(tcol_r);
  assign crow = (32'(trow_r) > SCREEN_ROWS - 1) ? RW'(SCREEN_ROWS - 1) : RW'(trow_r);
  assign kcl  = (32'(count_r) > SCREEN_ROWS) ? RH'(SCREEN_ROWS) : RH'(count_r);
  assign ecl  = (32'(endrow_r) > SCREEN_ROWS) ? RH'(SCREEN_ROWS) : RH'(endrow_r);
  assign clr_none = (32'(first_r) >= 32'(ecl));

  always_comb begin
    unique case (act_r)
      tcw_pkg::ACT_PUT:    row_a = RH'(cur_row_r);
      tcw_pkg::ACT_READ:   row_a = RH'(crow);
      tcw_pkg::ACT_SCROLL: row_a = kcl;
      tcw_pkg::ACT_CLEAR:  row_a = RH'(first_r);
      default:             row_a = '0;
    endcase
  end

  assign put_addr = AW'(prod_a_r + AW1'(cur_col_r));
  assign rd_addr  = AW'(prod_a_r + AW1'(ccol));
  assign sc_row   = (RH'(cur_row_r) > k_r) ? RW'(RH'(cur_row_r) - k_r) : '0;
  assign src_in   = (32'(src_r) < CELLS);

  // cursor after a put, before any scroll
  always_comb begin
    col_w  = CW1'(cur_col_r);
    row_w  = RH'(cur_row_r);
    put_wr = 1'b0;
    unique case (ch_r)
      tcw_pkg::CH_BACKSPACE: ;
      tcw_pkg::CH_TAB: begin
        col_w = (col_w + CW1'(tcw_pkg::TAB_STEP)) & ~CW1'(tcw_pkg::TAB_STEP - 1);
      end
      tcw_pkg::CH_CR: begin
        col_w = '0;
      end
      tcw_pkg::CH_LF: begin
        col_w = '0;
        row_w = row_w + RH'(1);
      end
      default: begin
        put_wr = 1'b1;
        col_w  = col_w + CW1'(1);
      end
    endcase
    if (32'(col_w) >= SCREEN_COLS) begin
      col_w = '0;
      row_w = row_w + RH'(1);
    end
    put_scroll = (32'(row_w) >= SCREEN_ROWS);
  end

  always_comb begin
    state_nxt   = state_r;
    cur_col_nxt = cur_col_r;
    cur_row_nxt = cur_row_r;
    prod_a_nxt  = prod_a_r;
    prod_b_nxt  = prod_b_r;
    k_nxt       = k_r;
    dst_nxt     = dst_r;
    src_nxt     = src_r;
    last_nxt    = last_r;
    clr_nxt     = clr_r;
    pend_nxt    = pend_r;
    pdst_nxt    = pdst_r;
    pblank_nxt  = pblank_r;
    mem_we      = 1'b0;
    mem_waddr   = pdst_r;
    mem_wdata   = pblank_r ? blank : mem_rdata;
    mem_raddr   = rd_addr;
    res         = '0;

    unique case (state_r)
      S_INIT: begin
        // clearing pass over the whole store after reset
        mem_we    = 1'b1;
        mem_waddr = dst_r;
        mem_wdata = {tcw_pkg::ATTR_RESET, {tcw_pkg::CHAR_W{1'b0}}};
        dst_nxt   = dst_r + AW'(1);
        if (dst_r == AW'(CELLS - 1)) begin
          dst_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        prod_a_nxt = AW1'(row_a) * AW1'(SCREEN_COLS);
        prod_b_nxt = AW1'(ecl) * AW1'(SCREEN_COLS);
        k_nxt      = kcl;
        state_nxt  = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_OUT;
        unique case (act_r)
          tcw_pkg::ACT_PUT: begin
            mem_we      = put_wr;
            mem_waddr   = put_addr;
            mem_wdata   = {attr, ch_r};
            cur_col_nxt = CW'(col_w);
            if (put_scroll) begin
              cur_row_nxt = RW'(SCREEN_ROWS - 1);
              dst_nxt     = '0;
              src_nxt     = AW1'(SCREEN_COLS);
              last_nxt    = AW'(CELLS - 1);
              clr_nxt     = 1'b0;
              pend_nxt    = 1'b0;
              state_nxt   = S_WALK;
            end else begin
              cur_row_nxt = RW'(row_w);
            end
          end
          tcw_pkg::ACT_MOVE: begin
            cur_col_nxt = ccol;
            cur_row_nxt = crow;
          end
          tcw_pkg::ACT_SCROLL: begin
            cur_row_nxt = sc_row;
            if (k_r != '0) begin
              dst_nxt   = '0;
              src_nxt   = prod_a_r;
              last_nxt  = AW'(CELLS - 1);
              clr_nxt   = 1'b0;
              pend_nxt  = 1'b0;
              state_nxt = S_WALK;
            end
          end
          tcw_pkg::ACT_CLEAR: begin
            if (!clr_none) begin
              dst_nxt   = AW'(prod_a_r);
              src_nxt   = prod_a_r;
              last_nxt  = AW'(prod_b_r - AW1'(1));
              clr_nxt   = 1'b1;
              pend_nxt  = 1'b0;
              state_nxt = S_WALK;
            end
          end
          default: ;
        endcase
      end
      S_WALK: begin
        // read the source row ahead, write the destination in the next cycle
        mem_we     = pend_r;
        mem_raddr  = src_in ? AW'(src_r) : '0;
        pend_nxt   = 1'b1;
        pdst_nxt   = dst_r;
        pblank_nxt = clr_r || !src_in;
        dst_nxt    = dst_r + AW'(1);
        src_nxt    = src_r + AW1'(1);
        if (dst_r == last_r) begin
          dst_nxt   = '0;
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        mem_we    = pend_r;
        pend_nxt  = 1'b0;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        res.done          = 1'b1;
        res.cursor_col    = tcw_pkg::OCOL_W'(cur_col_r);
        res.cursor_row    = tcw_pkg::OROW_W'(cur_row_r);
        res.cursor_offset = tcw_pkg::OFF_W'(AW1'(cur_row_r) * AW1'(SCREEN_COLS)
                                            + AW1'(cur_col_r));
        if (act_r == tcw_pkg::ACT_READ) begin
          res.cell_char = mem_rdata[tcw_pkg::CHAR_W-1:0];
          res.cell_attr = mem_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_INIT;
      cur_col_r <= '0;
      cur_row_r <= '0;
      dst_r     <= '0;
      pend_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cur_col_r <= cur_col_nxt;
      cur_row_r <= cur_row_nxt;
      dst_r     <= dst_nxt;
      pend_r    <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r    <= in_action;
      ch_r     <= in_char_code;
      tcol_r   <= in_target_col;
      trow_r   <= in_target_row;
      count_r  <= in_scroll_count;
      first_r  <= in_clear_first_row;
      endrow_r <= in_clear_end_row;
    end
    prod_a_r <= prod_a_nxt;
    prod_b_r <= prod_b_nxt;
    k_r      <= k_nxt;
    src_r    <= src_nxt;
    last_r   <= last_nxt;
    clr_r    <= clr_nxt;
    pdst_r   <= pdst_nxt;
    pblank_r <= pblank_nxt;
  end

endmodule

`default_nettype wire
